// ===== rtl/cli_pkg.sv =====
package cli_pkg;

  localparam int unsigned OpcodeWidth = 2;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned ValueWidth  = 32;

  typedef enum logic [OpcodeWidth-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2
  } opcode_e;

  localparam logic [StatusWidth-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatusWidth-1:0] ST_DELETED  = 3'd1;
  localparam logic [StatusWidth-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [StatusWidth-1:0] ST_EMPTY    = 3'd3;
  localparam logic [StatusWidth-1:0] ST_FULL     = 3'd4;
  localparam logic [StatusWidth-1:0] ST_ELEMENT  = 3'd5;

endpackage

// ===== rtl/cli_cmd_if.sv =====
interface cli_cmd_if import cli_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [OpcodeWidth-1:0]        opcode;
  logic signed [ValueWidth-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

// ===== rtl/cli_rsp_if.sv =====
interface cli_rsp_if import cli_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [StatusWidth-1:0]        status;
  logic signed [ValueWidth-1:0]  item_value;
  logic                          last;

  modport source (output valid, output status, output item_value, output last, input ready);
  modport sink (input valid, input status, input item_value, input last, output ready);
endinterface

// ===== rtl/circular_list_insert_delete_unit.sv =====
// Insert: the result is registered as the request is accepted.
// Delete: a single RAM read port walks the list once,
//   comparing against the key and then closing the gap one entry per cycle.
// Display: one element per cycle through the same read port while the response side is not stalled.
// One request in flight at a time. Reset (rst_ni low, asynchronous) empties the
//   list; entry storage is not cleared and needs no sweep.
module circular_list_insert_delete_unit import cli_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cli_cmd_if.sink    cmd_i,
  cli_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SRCH  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_DISP  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [ValueWidth-1:0]  key_q, key_d;
  logic [ValueWidth-1:0]  found_q, found_d;
  logic [StatusWidth-1:0] done_st_q, done_st_d;

  logic                   rsp_valid_q, rsp_valid_d;
  logic [StatusWidth-1:0] rsp_status_q, rsp_status_d;
  logic [ValueWidth-1:0]  rsp_value_q, rsp_value_d;
  logic                   rsp_last_q, rsp_last_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [ValueWidth-1:0]  ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [ValueWidth-1:0]  ram_rdata;

  logic                   can_load;
  logic                   cmd_ready;
  logic [CW-1:0]          ptr_inc;
  logic                   is_tail;

  cli_ram #(
    .WIDTH (ValueWidth),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign can_load = !rsp_valid_q || rsp_o.ready;
  assign ptr_inc  = CW'(ptr_q) + CW'(1);
  assign is_tail  = (ptr_inc == count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    key_d        = key_q;
    found_d      = found_q;
    done_st_d    = done_st_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_value_d  = rsp_value_q;
    rsp_last_d   = rsp_last_q;
    ram_we       = 1'b0;
    ram_waddr    = AW'(ptr_q - AW'(1));
    ram_wdata    = ram_rdata;
    ram_raddr    = ptr_inc[AW-1:0];
    cmd_ready    = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_ready = can_load;
        ram_raddr = '0;
        ptr_d     = '0;
        if (cmd_i.valid && can_load) begin
          case (cmd_i.opcode)
            OP_INSERT: begin
              rsp_valid_d = 1'b1;
              rsp_value_d = '0;
              rsp_last_d  = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                rsp_status_d = ST_FULL;
              end else begin
                ram_we       = 1'b1;
                ram_waddr    = count_q[AW-1:0];
                ram_wdata    = cmd_i.value;
                count_d      = count_q + CW'(1);
                rsp_status_d = ST_INSERTED;
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                rsp_valid_d  = 1'b1;
                rsp_status_d = ST_EMPTY;
                rsp_value_d  = '0;
                rsp_last_d   = 1'b1;
              end else begin
                key_d   = cmd_i.value;
                state_d = S_SRCH;
              end
            end
            OP_DISPLAY: begin
              if (count_q == '0) begin
                rsp_valid_d  = 1'b1;
                rsp_status_d = ST_EMPTY;
                rsp_value_d  = '0;
                rsp_last_d   = 1'b1;
              end else begin
                state_d = S_DISP;
              end
            end
            default: ;
          endcase
        end
      end

      S_SRCH: begin
        if (ram_rdata == key_q) begin
          found_d   = ram_rdata;
          done_st_d = ST_DELETED;
          if (is_tail) begin
            state_d = S_DONE;
          end else begin
            ptr_d   = ptr_inc[AW-1:0];
            state_d = S_SHIFT;
          end
        end else if (is_tail) begin
          found_d   = '0;
          done_st_d = ST_NOTFOUND;
          state_d   = S_DONE;
        end else begin
          ptr_d = ptr_inc[AW-1:0];
        end
      end

      S_SHIFT: begin
        // move entry at ptr down by one slot
        ram_we = 1'b1;
        if (is_tail) begin
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_inc[AW-1:0];
        end
      end

      S_DISP: begin
        if (can_load) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = ST_ELEMENT;
          rsp_value_d  = ram_rdata;
          rsp_last_d   = is_tail;
          if (is_tail) begin
            state_d = S_IDLE;
          end else begin
            ptr_d = ptr_inc[AW-1:0];
          end
        end else begin
          // hold the read data while the output is stalled
          ram_raddr = ptr_q;
        end
      end

      S_DONE: begin
        if (can_load) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = done_st_q;
          rsp_value_d  = found_q;
          rsp_last_d   = 1'b1;
          if (done_st_q == ST_DELETED) begin
            count_d = count_q - CW'(1);
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    found_q      <= found_d;
    done_st_q    <= done_st_d;
    rsp_status_q <= rsp_status_d;
    rsp_value_q  <= rsp_value_d;
    rsp_last_q   <= rsp_last_d;
  end

  assign cmd_i.ready      = cmd_ready;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.item_value = rsp_value_q;
  assign rsp_o.last       = rsp_last_q;

endmodule

// ===== rtl/cli_ram.sv =====
module cli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/testbench.sv =====
module testbench;
  import cli_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned SettleCycles = 2 * DEPTH + 8;
  localparam logic [OpcodeWidth-1:0] OpUndefined = 2'd3;

  typedef struct packed {
    logic [StatusWidth-1:0]       status;
    logic signed [ValueWidth-1:0] item_value;
    logic                         last;
  } list_rsp_t;

  logic clk_i;
  logic rst_ni;

  cli_cmd_if cmd_if ();
  cli_rsp_if rsp_if ();

  circular_list_insert_delete_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the list, head at index 0, and the responses it implies
  logic signed [ValueWidth-1:0] list_model[$];
  list_rsp_t                    expected_rsps[$];

  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned responses_seen;
  int unsigned max_fill;
  int unsigned stall_cycles;
  int unsigned ready_hold;
  bit          idle_on;

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic push_rsp(input logic [StatusWidth-1:0] status,
                          input logic signed [ValueWidth-1:0] item_value,
                          input logic last);
    list_rsp_t r;
    r.status     = status;
    r.item_value = item_value;
    r.last       = last;
    expected_rsps.push_back(r);
  endtask

  // Apply one accepted request to the shadow list
  task automatic predict_list_op(input logic [OpcodeWidth-1:0] op,
                                 input logic signed [ValueWidth-1:0] key);
    int hit;
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (list_model.size() >= DEPTH) begin
          push_rsp(ST_FULL, '0, 1'b1);
        end else begin
          list_model.push_back(key);
          push_rsp(ST_INSERTED, '0, 1'b1);
          if (list_model.size() > max_fill) max_fill = list_model.size();
        end
      end
      OP_DELETE: begin
        if (list_model.size() == 0) begin
          push_rsp(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_model.size(); i++) begin
            if (hit < 0 && list_model[i] == key) hit = i;
          end
          if (hit < 0) begin
            push_rsp(ST_NOTFOUND, '0, 1'b1);
          end else begin
            list_model.delete(hit);
            push_rsp(ST_DELETED, key, 1'b1);
          end
        end
      end
      OP_DISPLAY: begin
        if (list_model.size() == 0) begin
          push_rsp(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_model.size(); i++)
            push_rsp(ST_ELEMENT, list_model[i], i == list_model.size() - 1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [OpcodeWidth-1:0] op,
                          input logic signed [ValueWidth-1:0] val);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.value  <= val;
    do @(posedge clk_i); while (!cmd_if.ready);
    requests_sent++;
    predict_list_op(op, val);
  endtask

  // Drop valid and wait until every predicted response has come back
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_empty_list();
    send_cmd(OP_DELETE, '0);
    send_cmd(OP_DISPLAY, '0);
    send_cmd(OpUndefined, 32'sh1234_5678);
    send_cmd(OP_DELETE, 32'sh7fff_ffff);
    wait_drained();
  endtask

  task automatic test_fill_to_full();
    logic signed [ValueWidth-1:0] fill_vals[DEPTH];
    fill_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                  32'sd5, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd5,
                  32'sd1, -32'sd2, 32'sd100, 32'sh0000_ffff,
                  32'shffff_0000, 32'sd7, -32'sd7, 32'sd42};
    foreach (fill_vals[i]) send_cmd(OP_INSERT, fill_vals[i]);
    // one past full, then a full-length display
    send_cmd(OP_INSERT, 32'sd99);
    send_cmd(OP_DISPLAY, '0);
    wait_drained();
  endtask

  task automatic test_delete_cases();
    send_cmd(OP_DELETE, 32'sd5);
    send_cmd(OP_DELETE, 32'sd12345);
    send_cmd(OP_DELETE, 32'sh8000_0000);
    send_cmd(OP_DELETE, 32'sd42);
    send_cmd(OP_DISPLAY, 32'sh7fff_ffff);
    wait_drained();
  endtask

  // Sweep the fill level up to full and back down to empty, with keys
  // taken mostly from the live list so that deletes do real work
  task automatic test_random_traffic(input int n_items);
    int                           roll;
    bit                           filling;
    logic [OpcodeWidth-1:0]       op;
    logic signed [ValueWidth-1:0] val;
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      idle_on = (i < n_items - 60);
      if (list_model.size() == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (list_model.size() == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OpUndefined;
      else if (roll < 18) op = OP_DISPLAY;
      else if (roll < (filling ? 78 : 42)) op = OP_INSERT;
      else op = OP_DELETE;
      val = $urandom;
      if (op == OP_INSERT && $urandom_range(0, 2) == 0)
        val = int'($urandom_range(0, 6)) - 3;
      if (op == OP_DELETE && list_model.size() != 0 && $urandom_range(0, 3) != 0)
        val = list_model[$urandom_range(0, list_model.size() - 1)];
      send_cmd(op, val);
    end
    wait_drained();
  endtask

  // Response sink with random stall bursts
  always @(posedge clk_i) begin
    if (ready_hold > 0) ready_hold--;
    else if (rst_ni && idle_on && $urandom_range(0, 5) == 0) ready_hold = $urandom_range(1, 9);
    rsp_if.ready <= rst_ni && (ready_hold == 0);
  end

  // Response checker and watchdog
  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) stall_cycles = 0;
      if (rsp_if.valid && rsp_if.ready) begin
        stall_cycles = 0;
        responses_seen++;
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("unexpected response status=%0d value=%0d last=%0b",
                                    rsp_if.status, rsp_if.item_value, rsp_if.last));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
          if (rsp_if.item_value !== want.item_value)
            report_mismatch($sformatf("item_value %0d, want %0d",
                                      rsp_if.item_value, want.item_value));
          if (rsp_if.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", rsp_if.last, want.last));
        end
      end else if (!(cmd_if.valid && cmd_if.ready)) begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("Watchdog: no handshake for %0d cycles", stall_cycles);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.opcode = OP_INSERT;
    cmd_if.value  = '0;
    rsp_if.ready  = 1'b0;
    idle_on       = 1'b1;
    error_count   = 0;
    requests_sent = 0;
    responses_seen = 0;
    max_fill      = 0;
    stall_cycles  = 0;
    ready_hold    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_fill_to_full();
    test_delete_cases();
    test_random_traffic(285);

    if (expected_rsps.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));
    $display("Sent %0d requests (insert, delete, display, undefined opcode), checked %0d",
             requests_sent, responses_seen);
    $display("responses; list fill swept between empty and %0d of %0d entries",
             max_fill, DEPTH);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cli_pkg.sv
rtl/cli_cmd_if.sv
rtl/cli_rsp_if.sv
rtl/cli_ram.sv
rtl/circular_list_insert_delete_unit.sv
test/testbench.sv
